/* hdl/ellipse_tangent_velocity_assert.svh */
// ----------------------------------------------------------------------------
// ellipse tangent velocity assertion macros
// property wrappers that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_TANGENT_VELOCITY_ASSERT_SVH
`define ELLIPSE_TANGENT_VELOCITY_ASSERT_SVH

`ifndef SYNTHESIS
`define ETV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ETV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ETV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ETV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/etv_pkg.sv */
// ----------------------------------------------------------------------------
// etv_pkg
// shared widths, codes and helpers of the ellipse tangent velocity block
// ----------------------------------------------------------------------------
package etv_pkg;

  localparam int FracBitsDef = 16;

  localparam int CoordW  = 32;
  localparam int AxisW   = 31;
  localparam int SpeedW  = 32;
  localparam int CfgIdxW = 2;

  // root unit: 64 bit radicand, 32 bit root
  localparam int RadW  = 64;
  localparam int RootW = RadW / 2;

  // divider: dividend below 2^63, divisor and quotient 32 bits
  localparam int NumW  = 63;
  localparam int DenW  = 32;
  localparam int QuotW = 32;

  localparam int ProdW     = 2 * AxisW;
  localparam int NormSteps = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEMI_AXIS_X = 2'd0,
    REG_SEMI_AXIS_Y = 2'd1,
    REG_SPEED       = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_GENERAL   = 2'd0,
    KIND_ON_X_AXIS = 2'd1,
    KIND_ON_Y_AXIS = 2'd2,
    KIND_INVALID   = 2'd3
  } point_kind_e;

  typedef struct packed {
    point_kind_e kind;
    logic        x_neg;
    logic        y_neg;
    logic        y_zero;
  } point_tag_t;

  localparam int TagW = $bits(point_tag_t);

  // magnitude up to 2^31 with a sign, saturated to 32 bit two's complement
  function automatic logic [SpeedW-1:0] sat_signed(input logic [SpeedW-1:0] mag,
                                                   input logic neg);
    if (neg) begin
      return ~mag + 1'b1;
    end else if (mag[SpeedW-1]) begin
      return {1'b0, {(SpeedW-1){1'b1}}};
    end
    return mag;
  endfunction

endpackage

/* hdl/etv_chan_if.sv */
// ----------------------------------------------------------------------------
// etv channel interfaces
// point request channel and velocity result channel, valid/ready
// ----------------------------------------------------------------------------
interface etv_point_if import etv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x_pos;
  logic signed [CoordW-1:0] y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

interface etv_vel_if import etv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] vel_x;
  logic signed [SpeedW-1:0] vel_y;
  logic                     point_invalid;

  modport source (output valid, output vel_x, output vel_y, output point_invalid,
                  input ready);
  modport sink (input valid, input vel_x, input vel_y, input point_invalid,
                output ready);
endinterface

/* hdl/etv_isqrt.sv */
// ----------------------------------------------------------------------------
// etv_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module etv_isqrt import etv_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  localparam int Steps = RadW / 2;

  logic [RadW-1:0]  rem_in  [Steps];
  logic [RadW-1:0]  root_in [Steps];
  logic [RadW-1:0]  rem_d   [Steps];
  logic [RadW-1:0]  root_d  [Steps];
  logic [RadW-1:0]  rem_q   [Steps];
  logic [RadW-1:0]  root_q  [Steps];
  logic [SideW-1:0] side_q  [Steps];
  logic [Steps-1:0] valid_q;

  always_comb begin
    logic [RadW-1:0] step_w;
    logic [RadW-1:0] trial;
    rem_in[0]  = rad_i;
    root_in[0] = '0;
    for (int s = 1; s < Steps; s++) begin
      rem_in[s]  = rem_q[s-1];
      root_in[s] = root_q[s-1];
    end
    for (int s = 0; s < Steps; s++) begin
      step_w = RadW'(1) << (RadW - 2 - 2 * s);
      trial  = root_in[s] + step_w;
      if (rem_in[s] >= trial) begin
        rem_d[s]  = rem_in[s] - trial;
        root_d[s] = (root_in[s] >> 1) + step_w;
      end else begin
        rem_d[s]  = rem_in[s];
        root_d[s] = root_in[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < Steps; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < Steps; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = root_q[Steps-1][RootW-1:0];
  assign side_o  = side_q[Steps-1];

endmodule

/* hdl/etv_div.sv */
// ----------------------------------------------------------------------------
// etv_div
// pipelined restoring divider, two dividends over one shared divisor
// ----------------------------------------------------------------------------
module etv_div import etv_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_a_i,
  input  logic [NumW-1:0]  num_b_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_a_o,
  output logic [QuotW-1:0] quot_b_o,
  output logic [SideW-1:0] side_o
);

  localparam int Steps = QuotW;

  // quotient below 2^32, so the upper dividend bits start below the divisor
  logic [DenW-1:0]  rem_a_in [Steps];
  logic [DenW-1:0]  rem_b_in [Steps];
  logic [QuotW-1:0] low_a_in [Steps];
  logic [QuotW-1:0] low_b_in [Steps];
  logic [DenW-1:0]  den_in   [Steps];
  logic [DenW-1:0]  rem_a_d  [Steps];
  logic [DenW-1:0]  rem_b_d  [Steps];
  logic [QuotW-1:0] low_a_d  [Steps];
  logic [QuotW-1:0] low_b_d  [Steps];
  logic [DenW-1:0]  rem_a_q  [Steps];
  logic [DenW-1:0]  rem_b_q  [Steps];
  logic [QuotW-1:0] low_a_q  [Steps];
  logic [QuotW-1:0] low_b_q  [Steps];
  logic [DenW-1:0]  den_q    [Steps];
  logic [SideW-1:0] side_q   [Steps];
  logic [Steps-1:0] valid_q;

  always_comb begin
    logic [DenW:0] ta;
    logic [DenW:0] tb;
    rem_a_in[0] = DenW'(num_a_i[NumW-1:QuotW]);
    rem_b_in[0] = DenW'(num_b_i[NumW-1:QuotW]);
    low_a_in[0] = num_a_i[QuotW-1:0];
    low_b_in[0] = num_b_i[QuotW-1:0];
    den_in[0]   = den_i;
    for (int s = 1; s < Steps; s++) begin
      rem_a_in[s] = rem_a_q[s-1];
      rem_b_in[s] = rem_b_q[s-1];
      low_a_in[s] = low_a_q[s-1];
      low_b_in[s] = low_b_q[s-1];
      den_in[s]   = den_q[s-1];
    end
    for (int s = 0; s < Steps; s++) begin
      ta = {rem_a_in[s], low_a_in[s][QuotW-1]};
      tb = {rem_b_in[s], low_b_in[s][QuotW-1]};
      if (ta >= {1'b0, den_in[s]}) begin
        rem_a_d[s] = DenW'(ta - {1'b0, den_in[s]});
        low_a_d[s] = {low_a_in[s][QuotW-2:0], 1'b1};
      end else begin
        rem_a_d[s] = ta[DenW-1:0];
        low_a_d[s] = {low_a_in[s][QuotW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den_in[s]}) begin
        rem_b_d[s] = DenW'(tb - {1'b0, den_in[s]});
        low_b_d[s] = {low_b_in[s][QuotW-2:0], 1'b1};
      end else begin
        rem_b_d[s] = tb[DenW-1:0];
        low_b_d[s] = {low_b_in[s][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < Steps; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < Steps; s++) begin
        rem_a_q[s] <= rem_a_d[s];
        rem_b_q[s] <= rem_b_d[s];
        low_a_q[s] <= low_a_d[s];
        low_b_q[s] <= low_b_d[s];
        den_q[s]   <= den_in[s];
      end
    end
  end

  assign valid_o  = valid_q[Steps-1];
  assign quot_a_o = low_a_q[Steps-1];
  assign quot_b_o = low_b_q[Steps-1];
  assign side_o   = side_q[Steps-1];

endmodule

/* hdl/ellipse_tangent_velocity.sv */
// ----------------------------------------------------------------------------
// ellipse_tangent_velocity
// counter-clockwise tangent velocity of a point on an axis-aligned ellipse
// pipeline: two 32-stage root units and one 32-stage divider
// throughput: one request per cycle while the skid register is empty; a stalled result sits in it
// reset: async active low, semi-axes and speed return to 1.0, pipeline empties
// ----------------------------------------------------------------------------
`include "ellipse_tangent_velocity_assert.svh"

module ellipse_tangent_velocity import etv_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SpeedW-1:0]  cfg_data_i,
  etv_point_if.sink          point_i,
  etv_vel_if.source          vel_o
);

  localparam logic [63:0] One = 64'd1 << FracBits;

  // configuration
  logic [AxisW-1:0]  axis_a_q;
  logic [AxisW-1:0]  axis_b_q;
  logic [SpeedW-1:0] speed_q;
  logic [SpeedW-1:0] smag_q;
  logic              sneg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_a_q <= AxisW'(One);
      axis_b_q <= AxisW'(One);
      speed_q  <= SpeedW'(One);
      smag_q   <= SpeedW'(One);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SEMI_AXIS_X: axis_a_q <= cfg_data_i[AxisW-1:0];
        REG_SEMI_AXIS_Y: axis_b_q <= cfg_data_i[AxisW-1:0];
        REG_SPEED: begin
          speed_q <= cfg_data_i;
          smag_q  <= cfg_data_i[SpeedW-1] ? (~cfg_data_i + 1'b1) : cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  assign sneg = speed_q[SpeedW-1];

  logic en;
  logic skid_full_q;

  assign en            = !skid_full_q;
  assign point_i.ready = en;

  // stage 1: magnitude and signs
  logic              v1_q;
  logic [CoordW-1:0] ax1_q;
  logic              xneg1_q, yneg1_q, xzero1_q, yzero1_q;
  logic [CoordW-1:0] xu;

  assign xu = point_i.x_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q    <= xu[CoordW-1] ? (~xu + 1'b1) : xu;
      xneg1_q  <= point_i.x_pos[CoordW-1];
      yneg1_q  <= point_i.y_pos[CoordW-1];
      xzero1_q <= (point_i.x_pos == '0);
      yzero1_q <= (point_i.y_pos == '0);
    end
  end

  // stage 2: classify, a^2 and x^2
  logic             v2_q;
  point_tag_t       tag2_d, tag2_q;
  logic [ProdW-1:0] sqa2_q, sqx2_q;
  logic [AxisW-1:0] ax2_q;

  always_comb begin
    tag2_d.x_neg  = xneg1_q;
    tag2_d.y_neg  = yneg1_q;
    tag2_d.y_zero = yzero1_q;
    if (yzero1_q && !xzero1_q) begin
      tag2_d.kind = KIND_ON_X_AXIS;
    end else if (xzero1_q && !yzero1_q) begin
      tag2_d.kind = KIND_ON_Y_AXIS;
    end else if (axis_a_q == '0 || axis_b_q == '0 || ax1_q >= {1'b0, axis_a_q}) begin
      tag2_d.kind = KIND_INVALID;
    end else begin
      tag2_d.kind = KIND_GENERAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag2_q <= tag2_d;
      sqa2_q <= ProdW'(axis_a_q) * ProdW'(axis_a_q);
      sqx2_q <= ProdW'(ax1_q[AxisW-1:0]) * ProdW'(ax1_q[AxisW-1:0]);
      ax2_q  <= ax1_q[AxisW-1:0];
    end
  end

  // stage 3: root argument
  logic             v3_q;
  point_tag_t       tag3_q;
  logic [RadW-1:0]  rad3_q;
  logic [AxisW-1:0] ax3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag3_q <= tag2_q;
      rad3_q <= RadW'(sqa2_q - sqx2_q);
      ax3_q  <= ax2_q;
    end
  end

  // R = sqrt(a^2 - x^2)
  logic                   isq1_v;
  logic [RootW-1:0]       isq1_root;
  logic [TagW+AxisW-1:0]  isq1_side;

  etv_isqrt #(.SideW(TagW + AxisW)) u_isqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (rad3_q),
    .side_i  ({tag3_q, ax3_q}),
    .valid_o (isq1_v),
    .root_o  (isq1_root),
    .side_o  (isq1_side)
  );

  // stage 4: P = a*R, Q = b*|x|
  logic             v4_q;
  point_tag_t       tag4_q;
  logic [ProdW-1:0] p4_q, q4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= isq1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag4_q <= point_tag_t'(isq1_side[TagW+AxisW-1:AxisW]);
      p4_q   <= ProdW'(axis_a_q) * ProdW'(isq1_root[AxisW-1:0]);
      q4_q   <= ProdW'(axis_b_q) * ProdW'(isq1_side[AxisW-1:0]);
    end
  end

  // normalise: shift P and Q together until both fit 31 bits
  logic [ProdW-1:0]     nrm_p_in [NormSteps];
  logic [ProdW-1:0]     nrm_q_in [NormSteps];
  logic [ProdW-1:0]     nrm_p_d  [NormSteps];
  logic [ProdW-1:0]     nrm_q_d  [NormSteps];
  logic [ProdW-1:0]     nrm_p_q  [NormSteps];
  logic [ProdW-1:0]     nrm_q_q  [NormSteps];
  point_tag_t           nrm_tag_q [NormSteps];
  logic [NormSteps-1:0] nrm_v_q;

  always_comb begin
    logic [ProdW-1:0] both;
    int               sh;
    nrm_p_in[0] = p4_q;
    nrm_q_in[0] = q4_q;
    for (int s = 1; s < NormSteps; s++) begin
      nrm_p_in[s] = nrm_p_q[s-1];
      nrm_q_in[s] = nrm_q_q[s-1];
    end
    for (int s = 0; s < NormSteps; s++) begin
      sh   = 1 << (NormSteps - 1 - s);
      both = nrm_p_in[s] | nrm_q_in[s];
      if ((both >> (AxisW - 1 + sh)) != '0) begin
        nrm_p_d[s] = nrm_p_in[s] >> sh;
        nrm_q_d[s] = nrm_q_in[s] >> sh;
      end else begin
        nrm_p_d[s] = nrm_p_in[s];
        nrm_q_d[s] = nrm_q_in[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_v_q <= '0;
    end else if (en) begin
      nrm_v_q <= {nrm_v_q[NormSteps-2:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_tag_q[0] <= tag4_q;
      for (int s = 1; s < NormSteps; s++) begin
        nrm_tag_q[s] <= nrm_tag_q[s-1];
      end
      for (int s = 0; s < NormSteps; s++) begin
        nrm_p_q[s] <= nrm_p_d[s];
        nrm_q_q[s] <= nrm_q_d[s];
      end
    end
  end

  // stage 10: squares of the normalised pair
  logic             v10_q;
  point_tag_t       tag10_q;
  logic [AxisW-1:0] pn10_q, qn10_q;
  logic [ProdW-1:0] pp10_q, qq10_q;
  logic [AxisW-1:0] pn_w, qn_w;

  assign pn_w = nrm_p_q[NormSteps-1][AxisW-1:0];
  assign qn_w = nrm_q_q[NormSteps-1][AxisW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (en) begin
      v10_q <= nrm_v_q[NormSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag10_q <= nrm_tag_q[NormSteps-1];
      pn10_q  <= pn_w;
      qn10_q  <= qn_w;
      pp10_q  <= ProdW'(pn_w) * ProdW'(pn_w);
      qq10_q  <= ProdW'(qn_w) * ProdW'(qn_w);
    end
  end

  // stage 11: sum of squares
  logic             v11_q;
  point_tag_t       tag11_q;
  logic [AxisW-1:0] pn11_q, qn11_q;
  logic [RadW-1:0]  sum11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
    end else if (en) begin
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag11_q <= tag10_q;
      pn11_q  <= pn10_q;
      qn11_q  <= qn10_q;
      sum11_q <= RadW'(pp10_q) + RadW'(qq10_q);
    end
  end

  // N = sqrt(P'^2 + Q'^2)
  logic                    isq2_v;
  logic [RootW-1:0]        isq2_root;
  logic [TagW+2*AxisW-1:0] isq2_side;

  etv_isqrt #(.SideW(TagW + 2 * AxisW)) u_isqrt_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v11_q),
    .rad_i   (sum11_q),
    .side_i  ({tag11_q, pn11_q, qn11_q}),
    .valid_o (isq2_v),
    .root_o  (isq2_root),
    .side_o  (isq2_side)
  );

  // stage 12: speed products, zero norm check
  logic             v12_q;
  point_tag_t       tag12_d, tag12_q;
  logic [NumW-1:0]  na12_q, nb12_q;
  logic [DenW-1:0]  den12_q;

  always_comb begin
    tag12_d = point_tag_t'(isq2_side[TagW+2*AxisW-1:2*AxisW]);
    if (tag12_d.kind == KIND_GENERAL && isq2_root == '0) begin
      tag12_d.kind = KIND_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
    end else if (en) begin
      v12_q <= isq2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag12_q <= tag12_d;
      na12_q  <= NumW'(smag_q) * NumW'(isq2_side[2*AxisW-1:AxisW]);
      nb12_q  <= NumW'(smag_q) * NumW'(isq2_side[AxisW-1:0]);
      den12_q <= DenW'(isq2_root);
    end
  end

  // |speed| * P' / N and |speed| * Q' / N
  logic             div_v;
  logic [QuotW-1:0] div_qa, div_qb;
  logic [TagW-1:0]  div_side;
  point_tag_t       div_tag;

  etv_div #(.SideW(TagW)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v12_q),
    .num_a_i  (na12_q),
    .num_b_i  (nb12_q),
    .den_i    (den12_q),
    .side_i   (tag12_q),
    .valid_o  (div_v),
    .quot_a_o (div_qa),
    .quot_b_o (div_qb),
    .side_o   (div_side)
  );

  assign div_tag = point_tag_t'(div_side);

  // result stage: sign, saturate, select by point kind
  logic [SpeedW-1:0] fin_x, fin_y;
  logic              fin_inv;

  always_comb begin
    fin_x   = '0;
    fin_y   = '0;
    fin_inv = 1'b0;
    unique case (div_tag.kind)
      KIND_ON_X_AXIS: fin_y = sat_signed(smag_q, sneg ^ div_tag.x_neg);
      KIND_ON_Y_AXIS: begin
        fin_x = sat_signed(smag_q, sneg ^ (!div_tag.y_neg && !div_tag.y_zero));
      end
      KIND_INVALID: fin_inv = 1'b1;
      KIND_GENERAL: begin
        fin_x = sat_signed(div_qa, sneg ^ !div_tag.y_neg);
        fin_y = sat_signed(div_qb, sneg ^ div_tag.x_neg);
      end
      default: ;
    endcase
  end

  logic              out_v_q;
  logic [SpeedW-1:0] out_x_q, out_y_q;
  logic              out_inv_q;
  logic [SpeedW-1:0] skid_x_q, skid_y_q;
  logic              skid_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= fin_x;
      out_y_q   <= fin_y;
      out_inv_q <= fin_inv;
    end
  end

  // skid holds the result that the advancing pipeline would overwrite
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (vel_o.ready) begin
        skid_full_q <= 1'b0;
      end
    end else if (out_v_q && !vel_o.ready) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_x_q   <= out_x_q;
      skid_y_q   <= out_y_q;
      skid_inv_q <= out_inv_q;
    end
  end

  assign vel_o.valid         = skid_full_q | out_v_q;
  assign vel_o.vel_x         = skid_full_q ? skid_x_q : out_x_q;
  assign vel_o.vel_y         = skid_full_q ? skid_y_q : out_y_q;
  assign vel_o.point_invalid = skid_full_q ? skid_inv_q : out_inv_q;

  `ETV_ASSERT_IMPLY(a_invalid_is_zero, clk_i, rst_ni,
                    vel_o.valid && vel_o.point_invalid,
                    vel_o.vel_x == '0 && vel_o.vel_y == '0,
                    "invalid point with nonzero velocity")
  `ETV_ASSERT_NEXT(a_skid_capture, clk_i, rst_ni,
                   out_v_q && !vel_o.ready && !skid_full_q, skid_full_q,
                   "stalled result not captured in skid")
  `ETV_ASSERT_NEXT(a_skid_hold, clk_i, rst_ni, skid_full_q && !vel_o.ready,
                   skid_full_q && $stable(vel_o.vel_x) && $stable(vel_o.vel_y),
                   "skid result lost while stalled")

endmodule
